FILE: sv/mat4_pkg.sv
// shared constants and types of the fixed-point 4x4 matrix product
package mat4_pkg;

  localparam int DIM        = 4;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int INDEX_W    = 4;
  localparam int CELL_MAX_W = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic                  first;
    logic                  last_k;
    logic                  last_res;
    logic [CELL_MAX_W-1:0] pos;
  } tag_t;

endpackage

FILE: sv/mat4_in_if.sv
// element load channel: valid, ready and one element request
interface mat4_in_if #(
  parameter int IDX_W = mat4_pkg::INDEX_W,
  parameter int DW    = mat4_pkg::DATA_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic                 matrix_select;
  logic [IDX_W-1:0]     element_index;
  logic signed [DW-1:0] element_value;
  logic                 compute;

  modport source (output valid, matrix_select, element_index, element_value, compute,
                  input ready);
  modport sink (input valid, matrix_select, element_index, element_value, compute,
                output ready);
endinterface

FILE: sv/mat4_out_if.sv
// product element channel: valid, ready and one result element
interface mat4_out_if #(
  parameter int IDX_W = mat4_pkg::INDEX_W,
  parameter int DW    = mat4_pkg::DATA_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     result_index;
  logic signed [DW-1:0] result_value;
  logic                 saturated;
  logic                 last;

  modport source (output valid, result_index, result_value, saturated, last,
                  input ready);
  modport sink (input valid, result_index, result_value, saturated, last,
                output ready);
endinterface

FILE: sv/mat4_ram.sv
// generic single-write, single-read ram with registered read
module mat4_ram #(
  parameter int WIDTH = mat4_pkg::DATA_WIDTH,
  parameter int DEPTH = mat4_pkg::DIM * mat4_pkg::DIM
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/mat4_seq.sv
// sequencer: walks column, row and dot-product step, issues store reads
module mat4_seq #(
  parameter int DIM = mat4_pkg::DIM
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         en,
  input  logic                         busy,
  output logic                         idle,
  output logic [$clog2(DIM*DIM)-1:0]   raddr_l,
  output logic [$clog2(DIM*DIM)-1:0]   raddr_r,
  output mat4_pkg::tag_t               s1_tag
);

  localparam int KW = $clog2(DIM);
  localparam int AW = $clog2(DIM * DIM);
  localparam logic [KW-1:0] KLAST = KW'(DIM - 1);

  mat4_pkg::state_t state, state_next;
  logic [KW-1:0] k, row, col;
  logic [AW-1:0] pos;
  logic          issue;
  logic          last_issue;
  mat4_pkg::tag_t issue_tag;

  assign last_issue = (k == KLAST) && (row == KLAST) && (col == KLAST);
  assign raddr_l    = AW'(k * DIM + row);
  assign raddr_r    = AW'(col * DIM + k);

  always_comb begin
    state_next = state;
    unique case (state)
      mat4_pkg::ST_IDLE: begin
        if (start) state_next = mat4_pkg::ST_RUN;
      end
      mat4_pkg::ST_RUN: begin
        if (en && last_issue) state_next = mat4_pkg::ST_DRAIN;
      end
      mat4_pkg::ST_DRAIN: begin
        if (!busy && !s1_tag.valid) state_next = mat4_pkg::ST_IDLE;
      end
      default: state_next = mat4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idle  = (state == mat4_pkg::ST_IDLE);
    issue = (state == mat4_pkg::ST_RUN);
  end

  always_comb begin
    issue_tag          = '0;
    issue_tag.valid    = issue;
    issue_tag.first    = (k == '0);
    issue_tag.last_k   = (k == KLAST);
    issue_tag.last_res = (row == KLAST) && (col == KLAST);
    issue_tag.pos      = mat4_pkg::CELL_MAX_W'(pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mat4_pkg::ST_IDLE;
      k      <= '0;
      row    <= '0;
      col    <= '0;
      pos    <= '0;
      s1_tag <= '0;
    end else begin
      state <= state_next;
      if (en) begin
        s1_tag <= issue_tag;
      end
      if (start) begin
        k    <= '0;
        row  <= '0;
        col  <= '0;
        pos  <= '0;
      end else if (issue && en) begin
        if (k == KLAST) begin
          k    <= '0;
          pos  <= pos + 1'b1;
          if (row == KLAST) begin
            row <= '0;
            col <= col + 1'b1;
          end else begin
            row <= row + 1'b1;
          end
        end else begin
          k <= k + 1'b1;
        end
      end
    end
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == mat4_pkg::ST_IDLE)
    else $error("compute request taken while a product is in progress");

  a_drain_after_last: assert property (@(posedge clk) disable iff (rst)
    issue && en && last_issue |=> state == mat4_pkg::ST_DRAIN)
    else $error("sequencer kept issuing after the last read");

endmodule

FILE: sv/mat4_mac.sv
// multiply-accumulate pipeline with shift, saturation and output register
module mat4_mac #(
  parameter int DIM        = mat4_pkg::DIM,
  parameter int DATA_WIDTH = mat4_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = mat4_pkg::FRAC_BITS,
  parameter int IDX_W      = mat4_pkg::INDEX_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mat4_pkg::tag_t        s1_tag,
  input  logic [DATA_WIDTH-1:0] rd_l,
  input  logic [DATA_WIDTH-1:0] rd_r,
  output logic                  en,
  output logic                  busy,
  mat4_out_if.source            result
);

  localparam int DW    = DATA_WIDTH;
  localparam int H     = (DW + 1) / 2;
  localparam int HW    = DW - H;
  localparam int ACC_W = 2 * DW + $clog2(DIM);

  logic signed [DW-1:0]     a_s;
  logic signed [H:0]        b_lo;
  logic signed [HW-1:0]     b_hi;
  logic signed [DW+H:0]     p_lo;
  logic signed [DW+HW-1:0]  p_hi;
  mat4_pkg::tag_t           s2_tag;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     acc_done;
  logic [IDX_W-1:0]         res_cell;
  logic                     res_last;
  logic signed [ACC_W-1:0]  shifted;
  logic                     fits;
  logic signed [DW-1:0]     sat_val;

  assign en   = !result.valid || result.ready;
  assign busy = s2_tag.valid || acc_done;

  assign a_s  = $signed(rd_l);
  assign b_lo = $signed({1'b0, rd_r[H-1:0]});
  assign b_hi = $signed(rd_r[DW-1:H]);
  assign prod = ACC_W'(p_lo) + (ACC_W'(p_hi) <<< H);

  always_comb begin
    shifted = acc >>> FRAC_BITS;
    fits    = (&shifted[ACC_W-1:DW-1]) || !(|shifted[ACC_W-1:DW-1]);
    if (fits) begin
      sat_val = shifted[DW-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_val = $signed({1'b1, {(DW-1){1'b0}}});
    end else begin
      sat_val = $signed({1'b0, {(DW-1){1'b1}}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_tag       <= '0;
      acc_done     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (en) begin
        s2_tag   <= s1_tag;
        acc_done <= s2_tag.valid && s2_tag.last_k;
      end
      if (en && acc_done) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= a_s * b_lo;
      p_hi <= a_s * b_hi;
      if (s2_tag.valid) begin
        acc <= (s2_tag.first ? '0 : acc) + prod;
      end
      if (s2_tag.valid && s2_tag.last_k) begin
        res_cell <= IDX_W'(s2_tag.pos);
        res_last <= s2_tag.last_res;
      end
      if (acc_done) begin
        result.result_value <= sat_val;
        result.saturated    <= !fits;
        result.result_index <= res_cell;
        result.last         <= res_last;
      end
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(acc) && $stable(acc_done))
    else $error("accumulator moved while the output was stalled");

endmodule

FILE: sv/mat4_multiply.sv
// top level of the fixed-point matrix product block
//
// feed channel: each request writes one signed fixed-point element into the
// left (matrix_select 0) or right (matrix_select 1) store at its column-major
// element_index; indexes beyond the store are dropped. a request with compute
// set also starts the product left times right after its write.
// result channel: DIM*DIM elements in column-major order, last set on the
// final one, saturated set where the shifted sum was clipped to range.
// a compute request runs DIM^3 multiply-accumulate steps, one per cycle
// while the result channel is not stalled, on the shared multiplier fed by
// one read port of each store; each step passes the store read and partial
// product registers into the accumulator, and each finished sum then moves
// to the output register.
// feed.ready is low while a product is being computed.
// a stalled result stalls the whole pipeline; the next request can still be
// taken while the last result of a product waits in the output register.
// reset clears the sequencer and the output valid; store contents stay
// undefined until written.
module mat4_multiply #(
  parameter int DIM        = mat4_pkg::DIM,
  parameter int DATA_WIDTH = mat4_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = mat4_pkg::FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  mat4_in_if.sink    feed,
  mat4_out_if.source result
);

  localparam int NCELLS = DIM * DIM;
  localparam int AW     = $clog2(NCELLS);
  localparam int IDX_W  = (AW > mat4_pkg::INDEX_W) ? AW : mat4_pkg::INDEX_W;

  logic                  accept;
  logic                  in_range;
  logic                  start;
  logic                  en;
  logic                  busy;
  logic                  idle;
  logic [AW-1:0]         raddr_l, raddr_r;
  logic [DATA_WIDTH-1:0] rd_l, rd_r;
  mat4_pkg::tag_t        s1_tag;

  assign feed.ready = idle;
  assign accept     = feed.valid && feed.ready;
  assign in_range   = {1'b0, feed.element_index} < (IDX_W + 1)'(NCELLS);
  assign start      = accept && feed.compute;

  mat4_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NCELLS)) u_left (
    .clk   (clk),
    .we    (accept && in_range && !feed.matrix_select),
    .waddr (feed.element_index[AW-1:0]),
    .wdata (feed.element_value),
    .re    (en),
    .raddr (raddr_l),
    .rdata (rd_l)
  );

  mat4_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NCELLS)) u_right (
    .clk   (clk),
    .we    (accept && in_range && feed.matrix_select),
    .waddr (feed.element_index[AW-1:0]),
    .wdata (feed.element_value),
    .re    (en),
    .raddr (raddr_r),
    .rdata (rd_r)
  );

  mat4_seq #(.DIM(DIM)) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .en      (en),
    .busy    (busy),
    .idle    (idle),
    .raddr_l (raddr_l),
    .raddr_r (raddr_r),
    .s1_tag  (s1_tag)
  );

  mat4_mac #(
    .DIM        (DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .IDX_W      (IDX_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .s1_tag (s1_tag),
    .rd_l   (rd_l),
    .rd_r   (rd_r),
    .en     (en),
    .busy   (busy),
    .result (result)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    feed.ready |-> !s1_tag.valid && !busy)
    else $error("load taken while products are still in flight");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.last |-> result.result_index == IDX_W'(NCELLS - 1))
    else $error("last flag on a result other than the final element");

endmodule
